@@ rtl/core/e2r_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned FRAC_BITS_DEF     = 14;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // CORDIC working word: Q2.30 held in 34 bits for headroom.
  localparam int unsigned WB = 34;
  localparam int unsigned WORK_FRAC = 30;
  localparam logic signed [WB-1:0] INV_GAIN = 34'sd652032874;

  typedef logic signed [WB-1:0] work_t;

  // One CORDIC cell state.
  typedef struct packed {
    work_t       x;
    work_t       y;
    logic signed [32:0] z;
    logic        flip;
  } rot_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Rounded Q2.30 product, half up.
  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [2*WB-1:0] p;
    p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
    return p[WORK_FRAC +: WB];
  endfunction

endpackage

@@ rtl/core/e2r_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_cordic_cell
// One registered CORDIC rotation step for three angles side by side.
// ----------------------------------------------------------------------------
module e2r_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  e2r_pkg::rot_t   in_i  [3],
  output e2r_pkg::rot_t   out_o [3]
);

  localparam logic [4:0] IDX = 5'(STAGE);

  e2r_pkg::rot_t nxt [3];
  logic signed [32:0] at;

  assign at = $signed({1'b0, e2r_pkg::atan_turn(IDX)});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k] = in_i[k];
      if (!in_i[k].z[32]) begin
        nxt[k].x = in_i[k].x - (in_i[k].y >>> STAGE);
        nxt[k].y = in_i[k].y + (in_i[k].x >>> STAGE);
        nxt[k].z = in_i[k].z - at;
      end else begin
        nxt[k].x = in_i[k].x + (in_i[k].y >>> STAGE);
        nxt[k].y = in_i[k].y - (in_i[k].x >>> STAGE);
        nxt[k].z = in_i[k].z + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_o <= nxt;
    end
  end

endmodule

@@ rtl/core/e2r_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_matrix
// Three registered product stages forming the nine matrix entries.
// ----------------------------------------------------------------------------
module e2r_matrix #(
  parameter int unsigned FRAC_BITS = e2r_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  e2r_pkg::work_t        sc_i [6],
  output logic [FRAC_BITS+1:0]  ent_o [9]
);

  localparam int unsigned SH = e2r_pkg::WORK_FRAC - FRAC_BITS;

  // sc_i order: s0 c0 s1 c1 s2 c2
  e2r_pkg::work_t a_q [10];
  e2r_pkg::work_t b_q [9];
  logic [FRAC_BITS+1:0] o_d [9];

  function automatic logic [FRAC_BITS+1:0] sat(input e2r_pkg::work_t v);
    logic signed [e2r_pkg::WB:0] r;
    logic signed [e2r_pkg::WB:0] one;
    logic signed [e2r_pkg::WB:0] half;
    one = (e2r_pkg::WB+1)'(1) <<< FRAC_BITS;
    half = (e2r_pkg::WB+1)'(1) <<< (SH - 1);
    r = ($signed({v[e2r_pkg::WB-1], v}) + half) >>> SH;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[FRAC_BITS+1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= e2r_pkg::qmul(sc_i[5], sc_i[2]); // c2s1
      a_q[1] <= e2r_pkg::qmul(sc_i[4], sc_i[2]); // s2s1
      a_q[2] <= sc_i[0];
      a_q[3] <= sc_i[1];
      a_q[4] <= sc_i[2];
      a_q[5] <= sc_i[3];
      a_q[6] <= sc_i[4];
      a_q[7] <= sc_i[5];
      a_q[8] <= e2r_pkg::qmul(sc_i[5], sc_i[3]); // c2c1
      a_q[9] <= e2r_pkg::qmul(sc_i[4], sc_i[3]); // s2c1
      b_q[0] <= a_q[8];
      b_q[1] <= e2r_pkg::qmul(a_q[0], a_q[2]) - e2r_pkg::qmul(a_q[6], a_q[3]);
      b_q[2] <= e2r_pkg::qmul(a_q[0], a_q[3]) + e2r_pkg::qmul(a_q[6], a_q[2]);
      b_q[3] <= a_q[9];
      b_q[4] <= e2r_pkg::qmul(a_q[1], a_q[2]) + e2r_pkg::qmul(a_q[7], a_q[3]);
      b_q[5] <= e2r_pkg::qmul(a_q[1], a_q[3]) - e2r_pkg::qmul(a_q[7], a_q[2]);
      b_q[6] <= -a_q[4];
      b_q[7] <= e2r_pkg::qmul(a_q[5], a_q[2]);
      b_q[8] <= e2r_pkg::qmul(a_q[5], a_q[3]);
      ent_o  <= o_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) o_d[k] = sat(b_q[k]);
  end

endmodule

@@ rtl/core/euler_to_rotation_matrix_top.sv @@
`timescale 1ns / 1ps
// Pipeline: fold register, CORDIC cells, sine/cosine register, then the
// three product stages. Throughput: one angle triple per cycle unless the
// output stalls; all stages advance together as one stallable pipeline.
// A stall on the output holds every stage; tready follows downstream tready
// or an empty output slot.
// Reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// ZYX Euler angles to rotation matrix using a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top #(
  parameter int unsigned ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS     = e2r_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, then zero fill
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // entry_r0_c0 .. entry_r2_c2, then zero fill
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OW = FRAC_BITS + 2;
  localparam int unsigned DEPTH = CORDIC_STAGES + 5;
  localparam int unsigned OPAD = ((9*OW+7)/8)*8 - 9*OW;

  logic [DEPTH-1:0] vld_q, vld_d;
  logic en;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[DEPTH-1];
  assign vld_d = {vld_q[DEPTH-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Fold stage.
  e2r_pkg::rot_t chain [CORDIC_STAGES+1][3];
  e2r_pkg::rot_t fold_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] a;
      a = 32'(s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS);
      fold_d[k].flip = a[31] ^ a[30];
      if (fold_d[k].flip) a = a + 32'h80000000;
      fold_d[k].x = e2r_pkg::INV_GAIN;
      fold_d[k].y = '0;
      fold_d[k].z = $signed({a[31], a});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) chain[0] <= fold_d;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2r_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i(clk_i), .en_i(en), .in_i(chain[g]), .out_o(chain[g+1])
    );
  end

  e2r_pkg::work_t sc_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sc_q[2*k]   <= chain[CORDIC_STAGES][k].flip ? -chain[CORDIC_STAGES][k].y
                                                    : chain[CORDIC_STAGES][k].y;
        sc_q[2*k+1] <= chain[CORDIC_STAGES][k].flip ? -chain[CORDIC_STAGES][k].x
                                                    : chain[CORDIC_STAGES][k].x;
      end
    end
  end

  logic [OW-1:0] ent [9];
  e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i(clk_i), .en_i(en), .sc_i(sc_q), .ent_o(ent)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata[k*OW +: OW] = ent[k];
  end

  if (OPAD > 0) begin : g_pad
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready with empty output");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost");

endmodule
